FILE: design/bntg_pkg.sv
// ----------------------------------------------------------------------------
// bntg_pkg
// Shared types and constants of the buzzer note tone generator.
// ----------------------------------------------------------------------------
`default_nettype none
package bntg_pkg;

	localparam int FREQ_W   = 12;
	localparam int NUMER_W  = 18;
	localparam int LEN_W    = 16;
	localparam int CNT_W    = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 18;

	localparam logic [LEN_W-1:0]   NOTE_LEN_RST = 16'd12500;
	localparam logic [NUMER_W-1:0] NUMER_RST    = 18'd200000;

	// input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR   = 1'b1;

	typedef struct packed {
		logic              action;
		logic [FREQ_W-1:0] frequency;
	} in_word_t;

	typedef struct packed {
		logic level;
		logic note_done;
		logic busy_res;
	} out_word_t;

	// classified item as handed from front to back
	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_REST,
		KIND_TONE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [FREQ_W-1:0] frequency;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

endpackage
`default_nettype wire

FILE: design/bntg_front.sv
// ----------------------------------------------------------------------------
// bntg_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bntg_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	output logic                full,
	input  bntg_pkg::in_word_t  in_word,
	output bntg_pkg::head_t     head,
	input  wire                 head_pop
);
	import bntg_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;
	item_t      cls;

	// classify the incoming word
	always_comb begin
		cls.frequency = in_word.frequency;
		if (in_word.action == ACT_TICK) begin
			cls.kind = KIND_TICK;
		end else if (in_word.frequency == '0) begin
			cls.kind = KIND_REST;
		end else begin
			cls.kind = KIND_TONE;
		end
	end

	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = head_pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/bntg_div.sv
// ----------------------------------------------------------------------------
// bntg_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bntg_div (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire  [bntg_pkg::NUMER_W-1:0]         dividend,
	input  wire  [bntg_pkg::FREQ_W-1:0]          divisor,
	output logic                                 busy,
	output logic [bntg_pkg::NUMER_W-1:0]         quotient
);
	import bntg_pkg::*;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUMER_W-1:0] dvd_q;
	logic [FREQ_W-1:0]  rem_q;
	logic [FREQ_W-1:0]  dsr_q;
	logic [FREQ_W:0]    rem_sh;
	logic               ge;
	logic [FREQ_W:0]    rem_sub;

	// one restoring step
	always_comb begin
		rem_sh  = {rem_q, dvd_q[NUMER_W-1]};
		ge      = (rem_sh >= {1'b0, dsr_q});
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUMER_W-2:0], ge};
			rem_q <= ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUMER_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/bntg_back.sv
// ----------------------------------------------------------------------------
// bntg_back
// Note player: executes queued items, holds the tone state and the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module bntg_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  bntg_pkg::head_t                head,
	output logic                           head_pop,
	input  wire  [bntg_pkg::LEN_W-1:0]     note_length,
	input  wire  [bntg_pkg::NUMER_W-1:0]   numerator,
	output logic                           empty,
	input  wire                            pop,
	output bntg_pkg::out_word_t            out_word
);
	import bntg_pkg::*;

	back_state_t        state_q, state_d;
	logic               out_level_q, playing_q, is_rest_q;
	logic [NUMER_W-1:0] half_period_q, countdown_q;
	logic [LEN_W-1:0]   ticks_q;
	logic               res_valid_q;
	out_word_t          res_q;

	logic               out_level_d, playing_d, is_rest_d, done_d;
	logic [NUMER_W-1:0] half_period_d, countdown_d;
	logic [LEN_W-1:0]   ticks_d;

	logic               out_free;
	logic               take;
	logic               div_start;
	logic               div_busy;
	logic [NUMER_W-1:0] div_q;
	logic [NUMER_W-1:0] q_fix;
	logic               commit;
	logic               res_load;
	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W:0]     tick_next;

	bntg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numerator),
		.divisor  (head.item.frequency),
		.busy     (div_busy),
		.quotient (div_q)
	);

	assign out_free = !res_valid_q || pop;
	assign empty    = !res_valid_q;
	assign out_word = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (div_start) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (!div_busy && out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		take      = (state_q == BK_IDLE) && head.valid && out_free;
		head_pop  = take;
		div_start = take && (head.item.kind == KIND_TONE);
		commit    = (state_q == BK_DIV) && !div_busy && out_free;
		res_load  = (take && (head.item.kind != KIND_TONE)) || commit;
	end

	// note update
	always_comb begin
		len_eff       = (note_length == '0) ? LEN_W'(1) : note_length;
		tick_next     = {1'b0, ticks_q} + (LEN_W+1)'(1);
		q_fix         = (div_q == '0) ? NUMER_W'(1) : div_q;
		out_level_d   = out_level_q;
		playing_d     = playing_q;
		is_rest_d     = is_rest_q;
		half_period_d = half_period_q;
		countdown_d   = countdown_q;
		ticks_d       = ticks_q;
		done_d        = 1'b0;
		if (commit) begin
			playing_d     = 1'b1;
			ticks_d       = '0;
			is_rest_d     = 1'b0;
			half_period_d = q_fix;
			countdown_d   = q_fix;
		end else if (take) begin
			unique case (head.item.kind)
				KIND_REST: begin
					playing_d     = 1'b1;
					ticks_d       = '0;
					is_rest_d     = 1'b1;
					half_period_d = '0;
					countdown_d   = '0;
				end
				KIND_TICK: begin
					if (playing_q) begin
						if (tick_next >= {1'b0, len_eff}) begin
							playing_d = 1'b0;
							done_d    = 1'b1;
							ticks_d   = '0;
						end else begin
							ticks_d = tick_next[LEN_W-1:0];
							if (!is_rest_q) begin
								if (countdown_q <= NUMER_W'(1)) begin
									out_level_d = ~out_level_q;
									countdown_d = half_period_q;
								end else begin
									countdown_d = countdown_q - NUMER_W'(1);
								end
							end
						end
					end
				end
				default: begin
					// tone start waits for the divider
				end
			endcase
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.level     <= out_level_d;
			res_q.note_done <= done_d;
			res_q.busy_res  <= playing_d;
		end
	end

	// player state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			out_level_q   <= 1'b1;
			playing_q     <= 1'b0;
			is_rest_q     <= 1'b0;
			half_period_q <= '0;
			countdown_q   <= '0;
			ticks_q       <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			out_level_q   <= out_level_d;
			playing_q     <= playing_d;
			is_rest_q     <= is_rest_d;
			half_period_q <= half_period_d;
			countdown_q   <= countdown_d;
			ticks_q       <= ticks_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/buzzer_note_tone_generator.sv
// ----------------------------------------------------------------------------
// buzzer_note_tone_generator
// Square-wave buzzer tone generator stepped by timer tick words.
// ----------------------------------------------------------------------------
// usage
//   input queue: write a word with push while full is low. action start
//   loads a note of the given frequency (0 is a rest), action tick advances
//   the note timer by one tick.
//   result queue: one result word per input word, oldest first. it is on
//   out_word while empty is low and leaves on pop.
//   configuration: cfg_index 0 is note length in ticks, 1 the half-period
//   numerator; cfg_ready is always high. write only while the block is idle.
//   a tick or rest start reaches the result register through the intake
//   queue; a tone start also waits for the 18-step serial divider.
//   throughput: one tick word per cycle while results are popped and no
//   tone start is dividing. a two-word queue sits between intake and
//   player, so ticks can be pushed while the divider runs.
//   if the receiver stalls, the result stays in the output register and the
//   player and intake queue stop once that queue fills; nothing is lost.
//   reset: level high, no note playing, both queues empty, registers at
//   note length 12500 and numerator 200000.
// ----------------------------------------------------------------------------
`default_nettype none
module buzzer_note_tone_generator (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 push,
	output logic                                full,
	input  bntg_pkg::in_word_t                  in_word,
	output logic                                empty,
	input  wire                                 pop,
	output bntg_pkg::out_word_t                 out_word,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [bntg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bntg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bntg_pkg::*;

	logic [LEN_W-1:0]   note_length_q;
	logic [NUMER_W-1:0] numerator_q;
	head_t              head;
	logic               head_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_length_q <= NOTE_LEN_RST;
			numerator_q   <= NUMER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NOTE_LENGTH: note_length_q <= cfg_data[LEN_W-1:0];
				CFG_NUMERATOR:   numerator_q   <= cfg_data[NUMER_W-1:0];
				default:         note_length_q <= note_length_q;
			endcase
		end
	end

	bntg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.head     (head),
		.head_pop (head_pop)
	);

	bntg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_pop    (head_pop),
		.note_length (note_length_q),
		.numerator   (numerator_q),
		.empty       (empty),
		.pop         (pop),
		.out_word    (out_word)
	);

endmodule
`default_nettype wire

FILE: design/bntg_checker.sv
// ----------------------------------------------------------------------------
// bntg_checker
// Port-level checks of the buzzer note tone generator.
// ----------------------------------------------------------------------------
`default_nettype none
module bntg_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 push,
	input  wire                                 full,
	input  bntg_pkg::in_word_t                  in_word,
	input  wire                                 empty,
	input  wire                                 pop,
	input  bntg_pkg::out_word_t                 out_word,
	input  wire                                 cfg_valid,
	input  wire                                 cfg_ready,
	input  wire  [bntg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bntg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bntg_pkg::*;

	// a note that ends is no longer playing
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_word.note_done && out_word.busy_res))
		else $error("note_done word reports a note still playing");

	// the intake queue only fills on a push
	a_full_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("intake queue filled without a push");

	// a waiting result is held until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_word)))
		else $error("waiting result word dropped or changed");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind buzzer_note_tone_generator bntg_checker u_bntg_checker (.*);
`default_nettype wire

FILE: verif/buzzer_note_tone_generator_test.sv
// ----------------------------------------------------------------------------
// buzzer_note_tone_generator_test
// Drives start and tick words through the tone generator, takes each
// expected result word from the directed table or an internal model of the
// note player, and compares each popped word field by field. A directed
// table comes first, then random notes under several register settings,
// with bursty pushes and stalled pops.
`timescale 1ns / 1ps
module buzzer_note_tone_generator_test;
	import bntg_pkg::*;

	localparam int WORD_COUNT  = 1500;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_SLACK = 30;
	localparam int PLAN_ROWS   = 32;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		logic                  action;
		logic [FREQ_W-1:0]     frequency;
		logic                  typed;
		logic                  want_level;
		logic                  want_done;
		logic                  want_busy;
	} plan_row_t;

	typedef enum logic [1:0] {
		POP_ALWAYS,
		POP_RANDOM,
		POP_EVERY_FIFTH,
		POP_STALLS
	} pop_mode_t;

	// directed words: typed results only where they follow at a glance
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// idle tick after reset, then tone, tick, retrigger, rest
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b1, 1'b1, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd4095, 1'b1, 1'b1, 1'b0, 1'b1},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd1,    1'b1, 1'b1, 1'b0, 1'b1},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd0,    1'b1, 1'b1, 1'b0, 1'b1},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b1, 1'b1, 1'b0, 1'b1},
		// zero note length acts as one tick
		'{1'b1, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b1, 1'b1, 1'b1, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b1, 1'b1, 1'b0, 1'b0},
		// zero numerator: quotient floors to one, toggle every tick
		'{1'b1, CFG_NUMERATOR,   18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, CFG_NOTE_LENGTH, 18'd5, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd2048, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		// largest registers, largest half period
		'{1'b1, CFG_NUMERATOR,   18'h3FFFF, ACT_TICK, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, CFG_NOTE_LENGTH, 18'd65535, ACT_TICK, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd1,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		// small numerator: quotient one, equal, and below one
		'{1'b1, CFG_NUMERATOR,   18'd3, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b1, CFG_NOTE_LENGTH, 18'd4, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd2,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_TICK,  12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd3,    1'b0, 1'b0, 1'b0, 1'b0},
		'{1'b0, CFG_NOTE_LENGTH, 18'd0, ACT_START, 12'd4,    1'b0, 1'b0, 1'b0, 1'b0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	in_word_t              in_word   = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	out_word_t             out_word;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_NOTE_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// note player model state and its copy of the registers
	logic [LEN_W-1:0]   note_len;
	logic [NUMER_W-1:0] numer;
	logic               tone_level;
	logic               tone_playing;
	logic               tone_resting;
	logic [NUMER_W-1:0] half_per;
	logic [NUMER_W-1:0] countdown;
	logic [LEN_W-1:0]   ticks_done;

	out_word_t tone_results_due [$];
	int        mismatches   = 0;
	int        burst_left   = 0;
	int        idle_cycles  = 0;
	int        pop_cycle    = 0;
	int        pop_mode_left = 0;
	pop_mode_t pop_mode     = POP_ALWAYS;

	buzzer_note_tone_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.empty     (empty),
		.pop       (pop),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// next result word of the note player for one accepted word
	function automatic out_word_t advance_tone(input in_word_t w);
		logic         done;
		logic [16:0]  next_tick;
		logic [16:0]  len_eff;
		logic [NUMER_W-1:0] quot;
		done = 1'b0;
		if (w.action == ACT_START) begin
			tone_playing = 1'b1;
			ticks_done = '0;
			if (w.frequency == '0) begin
				tone_resting = 1'b1;
				half_per = '0;
				countdown = '0;
			end else begin
				quot = numer / NUMER_W'(w.frequency);
				if (quot == '0)
					quot = NUMER_W'(1);
				tone_resting = 1'b0;
				half_per = quot;
				countdown = quot;
			end
		end else if (tone_playing) begin
			len_eff = (note_len == '0) ? 17'd1 : {1'b0, note_len};
			next_tick = {1'b0, ticks_done} + 17'd1;
			if (next_tick >= len_eff) begin
				tone_playing = 1'b0;
				done = 1'b1;
				ticks_done = '0;
			end else begin
				ticks_done = next_tick[LEN_W-1:0];
				if (!tone_resting) begin
					if (countdown <= NUMER_W'(1)) begin
						tone_level = ~tone_level;
						countdown = half_per;
					end else begin
						countdown = countdown - NUMER_W'(1);
					end
				end
			end
		end
		return '{level: tone_level, note_done: done, busy_res: tone_playing};
	endfunction

	// push one word in bursts with random gaps, record its result
	task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
		int gap;
		out_word_t due;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (full);
		due = advance_tone(w);
		tone_results_due.push_back(typed ? want : due);
	endtask

	// hold pushes until every result word has been popped
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (tone_results_due.size() != 0);
	endtask

	// register write; valid is dropped by the next pushed word
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_NOTE_LENGTH)
			note_len = data[LEN_W-1:0];
		else
			numer = data[NUMER_W-1:0];
	endtask

	// stimulus
	initial begin
		in_word_t  w;
		out_word_t want;
		int        sent;
		int        phase_end;
		int        tick_run;
		int        len_cap;
		logic [CFG_DATA_W-1:0] pick_len;
		logic [CFG_DATA_W-1:0] pick_numer;

		note_len = NOTE_LEN_RST;
		numer = NUMER_RST;
		tone_level = 1'b1;
		tone_playing = 1'b0;
		tone_resting = 1'b0;
		half_per = '0;
		countdown = '0;
		ticks_done = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].is_cfg) begin
				if (i == 0 || !PLAN[i-1].is_cfg)
					wait_drained();
				write_reg(PLAN[i].reg_idx, PLAN[i].reg_data);
			end else begin
				w.action = PLAN[i].action;
				w.frequency = PLAN[i].frequency;
				want = '{level: PLAN[i].want_level, note_done: PLAN[i].want_done,
					busy_res: PLAN[i].want_busy};
				send_word(w, PLAN[i].typed, want);
			end
		end

		// random notes under changing register settings
		sent = 0;
		while (sent < WORD_COUNT) begin
			wait_drained();
			case ($urandom_range(0, 4))
				0: pick_len = CFG_DATA_W'($urandom_range(0, 2));
				1: pick_len = 18'd65535;
				2: pick_len = CFG_DATA_W'($urandom_range(3, 300));
				default: pick_len = CFG_DATA_W'($urandom_range(3, 40));
			endcase
			case ($urandom_range(0, 4))
				0: pick_numer = CFG_DATA_W'($urandom_range(0, 3));
				1: pick_numer = 18'h3FFFF;
				2: pick_numer = CFG_DATA_W'($urandom_range(1, 2000));
				default: pick_numer = CFG_DATA_W'($urandom_range(1, 262143));
			endcase
			write_reg(CFG_NOTE_LENGTH, pick_len);
			write_reg(CFG_NUMERATOR, pick_numer);
			len_cap = (note_len < 60) ? note_len : 60;
			phase_end = sent + $urandom_range(120, 240);
			while (sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray word of any kind
					w.action = 1'($urandom_range(0, 1));
					w.frequency = FREQ_W'($urandom_range(0, 4095));
					send_word(w, 1'b0, '0);
					sent++;
				end else begin
					// one note: start then a run of ticks
					w.action = ACT_START;
					case ($urandom_range(0, 5))
						0: w.frequency = '0;
						1: w.frequency = FREQ_W'($urandom_range(1, 16));
						2: w.frequency = 12'd4095;
						default: w.frequency = FREQ_W'($urandom_range(1, 4095));
					endcase
					send_word(w, 1'b0, '0);
					sent++;
					tick_run = $urandom_range(0, len_cap + 3);
					w.action = ACT_TICK;
					repeat (tick_run) begin
						w.frequency = FREQ_W'($urandom_range(0, 4095));
						send_word(w, 1'b0, '0);
						sent++;
					end
				end
				if ($urandom_range(0, 199) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (mismatches == 0)
			$display("buzzer_note_tone_generator: match");
		else
			$display("buzzer_note_tone_generator: mismatch");
		$finish;
	end

	// result side: check popped words, stall on changing patterns
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (tone_results_due.size() == 0) begin
					$display("%0t: result word with none expected, got %p", $time, out_word);
					mismatches++;
				end else begin
					want = tone_results_due.pop_front();
					if (out_word.level !== want.level) begin
						$display("%0t: level expected %0b got %0b",
							$time, want.level, out_word.level);
						mismatches++;
					end
					if (out_word.note_done !== want.note_done) begin
						$display("%0t: note_done expected %0b got %0b",
							$time, want.note_done, out_word.note_done);
						mismatches++;
					end
					if (out_word.busy_res !== want.busy_res) begin
						$display("%0t: busy_res expected %0b got %0b",
							$time, want.busy_res, out_word.busy_res);
						mismatches++;
					end
				end
			end
			if (pop_mode_left == 0) begin
				pop_mode <= pop_mode_t'($urandom_range(0, 3));
				pop_mode_left <= $urandom_range(20, 200);
			end else begin
				pop_mode_left <= pop_mode_left - 1;
			end
			pop_cycle <= pop_cycle + 1;
			case (pop_mode)
				POP_ALWAYS:      pop <= 1'b1;
				POP_RANDOM:      pop <= ($urandom_range(0, 9) < 6);
				POP_EVERY_FIFTH: pop <= (pop_cycle % 5 == 0);
				default:         pop <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("buzzer_note_tone_generator: mismatch");
				$finish;
			end
		end
	end

endmodule

FILE: filelist.f
design/bntg_pkg.sv
design/bntg_front.sv
design/bntg_div.sv
design/bntg_back.sv
design/buzzer_note_tone_generator.sv
design/bntg_checker.sv
verif/buzzer_note_tone_generator_test.sv
